@@ hw/rtl/mahd_pkg.sv @@
// Package for the MPEG audio header decoder: word types, constants and lookup tables.
`timescale 1ns / 1ps

package mahd_pkg;

   localparam int unsigned QUOT_W = 12;
   localparam int unsigned REM_W  = 26;
   localparam int unsigned DIV_W  = 17;

   localparam logic [7:0] SYNC_BYTE    = 8'hff;
   localparam logic [2:0] SYNC_BITS    = 3'b111;
   localparam logic [1:0] VER_MPEG25   = 2'd0;
   localparam logic [1:0] VER_RESERVED = 2'd1;
   localparam logic [1:0] VER_MPEG2    = 2'd2;
   localparam logic [1:0] VER_MPEG1    = 2'd3;
   localparam logic [1:0] LAYER_BITS_RESERVED = 2'd0;
   localparam logic [1:0] LAYER_I   = 2'd0;
   localparam logic [1:0] LAYER_II  = 2'd1;
   localparam logic [1:0] LAYER_III = 2'd2;
   localparam logic [3:0] BRI_BAD   = 4'hf;
   localparam logic [1:0] SRI_BAD   = 2'd3;

   localparam logic [2:0] COL_LSF_L1  = 3'd3;
   localparam logic [2:0] COL_LSF_L23 = 3'd4;

   localparam logic [17:0] MULT_L1  = 18'd12000;
   localparam logic [17:0] MULT_L23 = 18'd144000;
   localparam logic [18:0] KBPS_TO_BPS = 19'd1000;

   localparam logic [10:0] SAMPLES_L1  = 11'd384;
   localparam logic [10:0] SAMPLES_LSF = 11'd576;
   localparam logic [10:0] SAMPLES_STD = 11'd1152;

   typedef struct packed {
      logic              ok;
      logic [1:0]        version;
      logic [1:0]        layer;
      logic [18:0]       bitrate;
      logic [15:0]       srate;
      logic [10:0]       samples;
      logic              pad;
      logic              layer1;
      logic [REM_W-1:0]  rem;
      logic [DIV_W-1:0]  divisor;
      logic [QUOT_W-1:0] quot;
   } item_type;

   function automatic logic [8:0] kbps_lookup(input logic [3:0] bri, input logic [2:0] col);
      logic [8:0] r;
      r = 9'd0;
      case (col)
         3'd0: begin
            r = (bri == 4'hf) ? 9'd0 : 9'({5'd0, bri} * 9'd32);
         end
         3'd1: begin
            case (bri)
               4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;
               4'd4: r = 9'd64;   4'd5: r = 9'd80;   4'd6: r = 9'd96;
               4'd7: r = 9'd112;  4'd8: r = 9'd128;  4'd9: r = 9'd160;
               4'd10: r = 9'd192; 4'd11: r = 9'd224; 4'd12: r = 9'd256;
               4'd13: r = 9'd320; 4'd14: r = 9'd384;
               default: r = 9'd0;
            endcase
         end
         3'd2: begin
            case (bri)
               4'd1: r = 9'd32;   4'd2: r = 9'd40;   4'd3: r = 9'd48;
               4'd4: r = 9'd56;   4'd5: r = 9'd64;   4'd6: r = 9'd80;
               4'd7: r = 9'd96;   4'd8: r = 9'd112;  4'd9: r = 9'd128;
               4'd10: r = 9'd160; 4'd11: r = 9'd192; 4'd12: r = 9'd224;
               4'd13: r = 9'd256; 4'd14: r = 9'd320;
               default: r = 9'd0;
            endcase
         end
         3'd3: begin
            case (bri)
               4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;
               4'd4: r = 9'd64;   4'd5: r = 9'd80;   4'd6: r = 9'd96;
               4'd7: r = 9'd112;  4'd8: r = 9'd128;  4'd9: r = 9'd144;
               4'd10: r = 9'd160; 4'd11: r = 9'd176; 4'd12: r = 9'd192;
               4'd13: r = 9'd224; 4'd14: r = 9'd256;
               default: r = 9'd0;
            endcase
         end
         3'd4: begin
            case (bri)
               4'd1: r = 9'd8;    4'd2: r = 9'd16;   4'd3: r = 9'd24;
               4'd4: r = 9'd32;   4'd5: r = 9'd40;   4'd6: r = 9'd48;
               4'd7: r = 9'd56;   4'd8: r = 9'd64;   4'd9: r = 9'd80;
               4'd10: r = 9'd96;  4'd11: r = 9'd112; 4'd12: r = 9'd128;
               4'd13: r = 9'd144; 4'd14: r = 9'd160;
               default: r = 9'd0;
            endcase
         end
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] srate_lookup(input logic [1:0] sri, input logic [1:0] ver);
      logic [15:0] r;
      r = 16'd0;
      case (sri)
         2'd0: begin
            case (ver)
               VER_MPEG25: r = 16'd11025;
               VER_MPEG2:  r = 16'd22050;
               VER_MPEG1:  r = 16'd44100;
               default:    r = 16'd0;
            endcase
         end
         2'd1: begin
            case (ver)
               VER_MPEG25: r = 16'd12000;
               VER_MPEG2:  r = 16'd24000;
               VER_MPEG1:  r = 16'd48000;
               default:    r = 16'd0;
            endcase
         end
         2'd2: begin
            case (ver)
               VER_MPEG25: r = 16'd8000;
               VER_MPEG2:  r = 16'd16000;
               VER_MPEG1:  r = 16'd32000;
               default:    r = 16'd0;
            endcase
         end
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/mahd_decode.sv @@
// Front stage: header checks, table lookups, dividend and divisor set-up.
`timescale 1ns / 1ps

module mahd_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         byte0,
   input  logic [7:0]         byte1,
   input  logic [7:0]         byte2,
   output logic               out_valid,
   input  logic               out_ready,
   output mahd_pkg::item_type out_item
);

   logic               valid_ff;
   mahd_pkg::item_type item_ff;
   mahd_pkg::item_type item_in;

   logic        hdr_ok;
   logic [1:0]  ver;
   logic [1:0]  lay;
   logic [2:0]  col;
   logic [8:0]  kbps;
   logic [15:0] srate;
   logic        lsf_l3;
   logic [17:0] mult;
   logic [26:0] product;

   always_comb begin
      hdr_ok = (byte0 == mahd_pkg::SYNC_BYTE) && (byte1[7:5] == mahd_pkg::SYNC_BITS)
            && (byte1[4:3] != mahd_pkg::VER_RESERVED)
            && (byte1[2:1] != mahd_pkg::LAYER_BITS_RESERVED)
            && (byte2[7:4] != mahd_pkg::BRI_BAD) && (byte2[3:2] != mahd_pkg::SRI_BAD);
      ver    = byte1[4:3];
      lay    = 2'd3 - byte1[2:1];
      col    = (ver == mahd_pkg::VER_MPEG1) ? {1'b0, lay}
             : ((lay != mahd_pkg::LAYER_I) ? mahd_pkg::COL_LSF_L23 : mahd_pkg::COL_LSF_L1);
      kbps   = mahd_pkg::kbps_lookup(byte2[7:4], col);
      srate  = mahd_pkg::srate_lookup(byte2[3:2], ver);
      lsf_l3 = (lay == mahd_pkg::LAYER_III) && (ver != mahd_pkg::VER_MPEG1);
      mult   = (lay == mahd_pkg::LAYER_I) ? mahd_pkg::MULT_L1 : mahd_pkg::MULT_L23;
      product = 27'(kbps) * 27'(mult);

      item_in = '0;
      if (hdr_ok && (kbps != 9'd0)) begin
         item_in.ok      = 1'b1;
         item_in.version = ver;
         item_in.layer   = lay;
         item_in.bitrate = 19'(kbps) * mahd_pkg::KBPS_TO_BPS;
         item_in.srate   = srate;
         item_in.pad     = byte2[1];
         item_in.layer1  = (lay == mahd_pkg::LAYER_I);
         item_in.samples = (lay == mahd_pkg::LAYER_I) ? mahd_pkg::SAMPLES_L1
                         : (lsf_l3 ? mahd_pkg::SAMPLES_LSF : mahd_pkg::SAMPLES_STD);
         item_in.rem     = product[mahd_pkg::REM_W-1:0];
         item_in.divisor = lsf_l3 ? {srate, 1'b0} : {1'b0, srate};
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hw/rtl/mahd_div_cell.sv @@
// Divider cell: one restoring compare-and-subtract step, settles one quotient bit.
`timescale 1ns / 1ps

module mahd_div_cell #(
   parameter int unsigned BIT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  mahd_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output mahd_pkg::item_type out_item
);

   localparam int unsigned CMP_W = mahd_pkg::REM_W + 3;

   logic               valid_ff;
   mahd_pkg::item_type item_ff;
   mahd_pkg::item_type item_in;
   logic [CMP_W-1:0]   rem_x;
   logic [CMP_W-1:0]   div_x;
   logic [CMP_W-1:0]   diff;

   always_comb begin
      rem_x   = CMP_W'(in_item.rem);
      div_x   = CMP_W'(in_item.divisor) << BIT;
      diff    = rem_x - div_x;
      item_in = in_item;
      if (rem_x >= div_x) begin
         item_in.rem       = diff[mahd_pkg::REM_W-1:0];
         item_in.quot[BIT] = 1'b1;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hw/rtl/mpeg_audio_header_decoder.sv @@
// Top level: MPEG audio frame header decoder, decode stage, divider cell chain, output register.
//
//  channel | dir | bits     | contents
//  req     | in  | 24       | header bytes 0..2
//  rsp     | out | 64 + 1   | decoded header, tuser = header accepted
//
//  One word accepted per cycle while rsp is not stalled; each word passes through the decode register,
//  the chain of 12 divider cells, one quotient bit each, and the output register
//  on its way from req to rsp.
//  Reset clears only the stage valid flags; the chain is empty after reset.
//  A stall on rsp fills the chain one stage at a time; bubbles are squeezed out.
`timescale 1ns / 1ps

module mpeg_audio_header_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] header_byte0, [15:8] header_byte1, [23:16] header_byte2
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] version_code, [3:2] layer_code, [22:4] bitrate_bps, [38:23] sample_rate_hz,
   // [50:39] frame_bytes, [61:51] frame_samples, [63:62] zero
   output logic [63:0] rsp_tdata,
   // [0] valid_res
   output logic        rsp_tuser
);

   localparam int unsigned NCELL = mahd_pkg::QUOT_W;

   mahd_pkg::item_type chain_item  [NCELL+1];
   logic               chain_valid [NCELL+1];
   logic               chain_ready [NCELL+1];

   logic               rsp_valid_ff;
   logic [63:0]        rsp_data_ff;
   logic               rsp_user_ff;
   logic [63:0]        rsp_data_in;
   logic               out_load;
   logic [11:0]        bytes_raw;
   logic [11:0]        bytes_fin;
   mahd_pkg::item_type last;

   mahd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .byte0     (req_tdata[7:0]),
      .byte1     (req_tdata[15:8]),
      .byte2     (req_tdata[23:16]),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_item  (chain_item[0])
   );

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      mahd_div_cell #(
         .BIT (NCELL - 1 - g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_item   (chain_item[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_item  (chain_item[g+1])
      );
   end

   assign last             = chain_item[NCELL];
   assign chain_ready[NCELL] = !rsp_valid_ff || rsp_tready;
   assign out_load         = chain_ready[NCELL] && chain_valid[NCELL];

   always_comb begin
      bytes_raw   = last.quot + 12'(last.pad);
      bytes_fin   = last.layer1 ? {bytes_raw[9:0], 2'b00} : bytes_raw;
      rsp_data_in = '0;
      if (last.ok) begin
         rsp_data_in[1:0]   = last.version;
         rsp_data_in[3:2]   = last.layer;
         rsp_data_in[22:4]  = last.bitrate;
         rsp_data_in[38:23] = last.srate;
         rsp_data_in[50:39] = bytes_fin;
         rsp_data_in[61:51] = last.samples;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_ready[NCELL]) begin
         rsp_valid_ff <= chain_valid[NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= last.ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ hw/rtl/mahd_checker.sv @@
// Port checker for the MPEG audio header decoder, bound to the top level.
`timescale 1ns / 1ps

module mahd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("rejected header carries non-zero fields");

   a_samples: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[61:51] == 11'd384) || (rsp_tdata[61:51] == 11'd576)
         || (rsp_tdata[61:51] == 11'd1152))
      else $error("accepted header with bad samples per frame");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp word valid straight after reset");

endmodule

bind mpeg_audio_header_decoder mahd_checker u_mahd_checker (.*);
